>>> rtl/dpd_pkg.sv
// dpd_pkg: types, constants and lookup functions for the display packet decoder
// used by dpd_front, dpd_queue, dpd_back and display_packet_decoder
`default_nettype none

package dpd_pkg;

  localparam int CapBytes = 13;
  localparam int CapIdxW  = $clog2(CapBytes);

  localparam logic [7:0] StartByte = 8'hAA;
  localparam logic [7:0] EndByte   = 8'hAB;

  localparam logic [7:0] IdAck01   = 8'h01;
  localparam logic [7:0] IdVersion = 8'h02;
  localparam logic [7:0] IdAck12   = 8'h12;
  localparam logic [7:0] IdAck13   = 8'h13;
  localparam logic [7:0] IdDisplay = 8'h31;
  localparam logic [7:0] IdDispOff = 8'h32;
  localparam logic [7:0] IdDispOn  = 8'h33;
  localparam logic [7:0] IdAck34   = 8'h34;
  localparam logic [7:0] IdAck35   = 8'h35;
  localparam logic [7:0] IdAck36   = 8'h36;
  localparam logic [7:0] IdAck39   = 8'h39;
  localparam logic [7:0] IdAck3C   = 8'h3C;
  localparam logic [7:0] IdVolume  = 8'h3D;
  localparam logic [7:0] IdAlert   = 8'h43;

  localparam int FlagMuted    = 0;
  localparam int FlagSoftMute = 1;
  localparam int FlagSystem   = 2;
  localparam int FlagDispOn   = 3;
  localparam int FlagOnKnown  = 4;
  localparam int FlagVolKnown = 5;
  localparam int FlagVerKnown = 6;

  typedef enum logic [2:0] {
    KindReject,
    KindDisplay,
    KindVersion,
    KindVolume,
    KindOffAck,
    KindOnAck,
    KindOtherAck,
    KindAlert
  } kind_t;

  // one classified packet, bytes 5 to 12 as captured
  typedef struct packed {
    kind_t      kind;
    logic       vol_long;
    logic       ver_ok;
    logic       vol_ok;
    logic [7:0] b12;
    logic [7:0] b11;
    logic [7:0] b10;
    logic [7:0] b9;
    logic [7:0] b8;
    logic [7:0] b7;
    logic [7:0] b6;
    logic [7:0] b5;
  } pkt_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic logic [6:0] glyph_of(input logic [6:0] seg);
    logic [6:0] g;
    case (seg)
      7'd6:    g = 7'h31;
      7'd7:    g = 7'h37;
      7'd24:   g = 7'h26;
      7'd28:   g = 7'h75;
      7'd30:   g = 7'h4A;
      7'd56:   g = 7'h4C;
      7'd57:   g = 7'h43;
      7'd62:   g = 7'h55;
      7'd63:   g = 7'h30;
      7'd73:   g = 7'h23;
      7'd79:   g = 7'h33;
      7'd88:   g = 7'h63;
      7'd91:   g = 7'h32;
      7'd94:   g = 7'h64;
      7'd102:  g = 7'h34;
      7'd109:  g = 7'h35;
      7'd111:  g = 7'h39;
      7'd113:  g = 7'h46;
      7'd115:  g = 7'h50;
      7'd119:  g = 7'h41;
      7'd121:  g = 7'h45;
      7'd124:  g = 7'h62;
      7'd125:  g = 7'h36;
      7'd127:  g = 7'h38;
      default: g = 7'h20;
    endcase
    return g;
  endfunction

  function automatic logic [6:0] mode_of(input logic [6:0] seg);
    logic [6:0] m;
    case (seg)
      7'h77:   m = 7'h41;
      7'h39:   m = 7'h43;
      7'h3E:   m = 7'h55;
      7'h18:   m = 7'h6C;
      7'h1C:   m = 7'h75;
      7'h58:   m = 7'h63;
      7'h38:   m = 7'h4C;
      default: m = 7'h00;
    endcase
    return m;
  endfunction

  function automatic logic [2:0] bars_of(input logic [7:0] map);
    logic [2:0] b;
    case (map)
      8'd0:    b = 3'd0;
      8'd1:    b = 3'd1;
      8'd3:    b = 3'd2;
      8'd7:    b = 3'd3;
      8'd15:   b = 3'd4;
      8'd31:   b = 3'd5;
      default: b = 3'd6;
    endcase
    return b;
  endfunction

  function automatic logic is_digit(input logic [7:0] v);
    return (v >= 8'h30) && (v <= 8'h39);
  endfunction

endpackage

`default_nettype wire

>>> rtl/dpd_front.sv
// dpd_front: byte intake, position count, capture of header bytes and
// end-of-packet framing check and classification; depends on dpd_pkg
`default_nettype none

module dpd_front (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_tvalid,
  output logic                in_tready,
  input  wire logic [7:0]     in_tdata,   // [7:0] rx_byte
  input  wire logic           in_tlast,   // packet_end
  input  wire dpd_pkg::q_stat_t q_stat,
  output logic                push,
  output dpd_pkg::pkt_t       push_data
);
  import dpd_pkg::*;

  logic [7:0] pos_r, pos_nxt;
  logic [7:0] cap_r [CapBytes];
  logic       accept;
  logic [7:0] id;
  logic       frame_ok;
  logic       short_ack;
  kind_t      kind;

  assign in_tready = !q_stat.full;
  assign accept    = in_tvalid && in_tready;
  assign push      = accept && in_tlast;
  assign id        = cap_r[3];

  // pos_r is the index of the current byte, so length = pos_r + 1
  assign frame_ok  = (pos_r >= 8'd6) && (cap_r[0] == StartByte) && (in_tdata == EndByte);
  assign short_ack = (id == IdAck01) || (id == IdAck12) || (id == IdAck13) ||
                     (id == IdAck34) || (id == IdAck35) || (id == IdAck36) ||
                     (id == IdAck39);

  always_comb begin
    kind = KindReject;
    if (frame_ok) begin
      if (short_ack) begin
        kind = KindOtherAck;
      end else if (id == IdDispOff) begin
        kind = KindOffAck;
      end else if (id == IdDispOn) begin
        kind = KindOnAck;
      end else if (pos_r >= 8'd7) begin
        case (id)
          IdDisplay: kind = (pos_r >= 8'd13) ? KindDisplay : KindReject;
          IdAlert:   kind = KindAlert;
          IdVersion: kind = KindVersion;
          IdVolume:  kind = KindVolume;
          IdAck3C:   kind = KindOtherAck;
          default:   kind = KindReject;
        endcase
      end
    end
  end

  always_comb begin
    push_data.kind     = kind;
    push_data.vol_long = (pos_r >= 8'd14);
    push_data.vol_ok   = (pos_r >= 8'd9) && (cap_r[4] >= 8'd4);
    push_data.ver_ok   = (pos_r >= 8'd12) && (cap_r[4] >= 8'd7) &&
                         ((cap_r[5] == 8'h76) || (cap_r[5] == 8'h56)) &&
                         is_digit(cap_r[6]) && (cap_r[7] == 8'h2E) &&
                         is_digit(cap_r[8]) && is_digit(cap_r[9]) &&
                         is_digit(cap_r[10]) && is_digit(cap_r[11]);
    push_data.b5       = cap_r[5];
    push_data.b6       = cap_r[6];
    push_data.b7       = cap_r[7];
    push_data.b8       = cap_r[8];
    push_data.b9       = cap_r[9];
    push_data.b10      = cap_r[10];
    push_data.b11      = cap_r[11];
    push_data.b12      = cap_r[12];
  end

  always_comb begin
    pos_nxt = pos_r;
    if (accept) begin
      if (in_tlast) begin
        pos_nxt = 8'd0;
      end else if (pos_r != 8'hFF) begin
        pos_nxt = pos_r + 8'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= 8'd0;
    end else begin
      pos_r <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (pos_r < 8'(CapBytes))) begin
      cap_r[pos_r[CapIdxW-1:0]] <= in_tdata;
    end
  end

endmodule

`default_nettype wire

>>> rtl/dpd_queue.sv
// dpd_queue: two-entry queue of classified packets between front and back
// depends on dpd_pkg
`default_nettype none

module dpd_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire dpd_pkg::pkt_t push_data,
  input  wire logic          pop,
  output dpd_pkg::pkt_t      head,
  output dpd_pkg::q_stat_t   q_stat
);
  import dpd_pkg::*;

  pkt_t       mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign head         = mem_r[rd_ptr_r];
  assign q_stat.full  = (cnt_r == 2'd2);
  assign q_stat.empty = (cnt_r == 2'd0);

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

>>> rtl/dpd_back.sv
// dpd_back: applies classified packets to the held display, flag, volume and
// version state and registers one result per packet; depends on dpd_pkg
`default_nettype none

module dpd_back (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic [3:0]      mute_confirm,
  input  wire dpd_pkg::pkt_t   head,
  input  wire dpd_pkg::q_stat_t q_stat,
  output logic                 pop,
  output logic                 out_tvalid,
  input  wire logic            out_tready,
  output logic [71:0]          out_tdata,  // glyph, dot, mode, bands, arrows, flash,
                                           // bars, flags, volumes, version; zero pad
  output logic [3:0]           out_tuser   // [0] accepted, [3:1] packet_kind
);
  import dpd_pkg::*;

  logic [6:0]  glyph_r, glyph_nxt;
  logic        dot_r, dot_nxt;
  logic [6:0]  mode_r, mode_nxt;
  logic [3:0]  bands_r, bands_nxt;
  logic [2:0]  arrows_r, arrows_nxt;
  logic [7:0]  flash_r, flash_nxt;
  logic [2:0]  bars_r, bars_nxt;
  logic [6:0]  flags_r, flags_nxt;
  logic [7:0]  vol_r, vol_nxt;
  logic [16:0] ver_r, ver_nxt;
  logic [3:0]  run_r, run_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [71:0] out_data_r;
  logic [3:0]  out_user_r;
  logic        sys;
  logic [16:0] ver_val;

  assign pop        = !q_stat.empty && (!out_valid_r || out_tready);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign sys        = head.b10[2];

  assign ver_val = 17'(head.b6[3:0]) * 17'd10000 + 17'(head.b8[3:0]) * 17'd1000 +
                   17'(head.b9[3:0]) * 17'd100 + 17'(head.b10[3:0]) * 17'd10 +
                   17'(head.b11[3:0]);

  always_comb begin
    glyph_nxt  = glyph_r;
    dot_nxt    = dot_r;
    mode_nxt   = mode_r;
    bands_nxt  = bands_r;
    arrows_nxt = arrows_r;
    flash_nxt  = flash_r;
    bars_nxt   = bars_r;
    flags_nxt  = flags_r;
    vol_nxt    = vol_r;
    ver_nxt    = ver_r;
    run_nxt    = run_r;
    if (pop) begin
      case (head.kind)
        KindDisplay: begin
          glyph_nxt  = glyph_of(head.b5[6:0]);
          dot_nxt    = head.b5[7];
          mode_nxt   = mode_of(head.b5[6:0]);
          bands_nxt  = sys ? head.b8[3:0] : 4'd0;
          arrows_nxt = sys ? head.b8[7:5] : 3'd0;
          flash_nxt  = sys ? (head.b8 & ~head.b9 & 8'hEF) : 8'd0;
          bars_nxt   = bars_of(head.b7);
          if (head.b8[4]) begin
            run_nxt = (run_r < mute_confirm) ? run_r + 4'd1 : run_r;
          end else begin
            run_nxt = 4'd0;
          end
          flags_nxt[FlagMuted]    = (run_nxt >= mute_confirm);
          flags_nxt[FlagSoftMute] = head.b10[0];
          flags_nxt[FlagSystem]   = sys;
          if (head.vol_long) begin
            vol_nxt                 = head.b12;
            flags_nxt[FlagVolKnown] = 1'b1;
          end
        end
        KindVersion: begin
          if (head.ver_ok) begin
            ver_nxt                 = ver_val;
            flags_nxt[FlagVerKnown] = 1'b1;
          end
        end
        KindVolume: begin
          if (head.vol_ok) begin
            vol_nxt                 = {head.b5[3:0], head.b6[3:0]};
            flags_nxt[FlagVolKnown] = 1'b1;
          end
        end
        KindOffAck: begin
          flags_nxt[FlagDispOn]  = 1'b0;
          flags_nxt[FlagOnKnown] = 1'b1;
        end
        KindOnAck: begin
          flags_nxt[FlagDispOn]  = 1'b1;
          flags_nxt[FlagOnKnown] = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (pop) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      glyph_r     <= '0;
      dot_r       <= 1'b0;
      mode_r      <= '0;
      bands_r     <= '0;
      arrows_r    <= '0;
      flash_r     <= '0;
      bars_r      <= '0;
      flags_r     <= '0;
      vol_r       <= '0;
      ver_r       <= '0;
      run_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      glyph_r     <= glyph_nxt;
      dot_r       <= dot_nxt;
      mode_r      <= mode_nxt;
      bands_r     <= bands_nxt;
      arrows_r    <= arrows_nxt;
      flash_r     <= flash_nxt;
      bars_r      <= bars_nxt;
      flags_r     <= flags_nxt;
      vol_r       <= vol_nxt;
      ver_r       <= ver_nxt;
      run_r       <= run_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_user_r <= {head.kind, head.kind != KindReject};
      out_data_r <= {7'd0, ver_nxt, vol_nxt, flags_nxt, bars_nxt, flash_nxt,
                     arrows_nxt, bands_nxt, mode_nxt, dot_nxt, glyph_nxt};
    end
  end

endmodule

`default_nettype wire

>>> rtl/display_packet_decoder.sv
// display_packet_decoder: top level, configuration register and assertions
// depends on dpd_pkg, dpd_front, dpd_queue and dpd_back
`default_nettype none

// Takes one packet byte per cycle while in_tready is high, with tlast on the
// last byte, and gives one result per packet: framing verdict, kind and the
// held display, flag, volume and firmware version state. A front stage counts
// and captures bytes and classifies the packet at its last byte. A two-entry
// packet queue feeds the back stage, which updates the held state and loads
// the output register in the same cycle. Sustained rate is one byte per cycle
// while the output is not stalled. A stalled output first fills the queue and
// then holds off the input until a result is taken. mute_confirm_count sits at
// address 0 of the register port; the user must write it only while the block
// is idle, and the block itself does not enforce this.
module display_packet_decoder (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] rx_byte
  input  wire logic        in_tlast,   // packet_end
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [71:0]      out_tdata,  // [6:0] bogey_glyph, [7] bogey_dot,
                                       // [14:8] mode_glyph, [18:15] active_bands,
                                       // [21:19] arrows, [29:22] flash_bits,
                                       // [32:30] signal_bars, [39:33] status_flags,
                                       // [47:40] volumes, [64:48] firmware_version
  output logic [3:0]       out_tuser,  // [0] accepted, [3:1] packet_kind
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);
  import dpd_pkg::*;

  logic       push;
  pkt_t       push_data;
  logic       pop;
  pkt_t       head;
  q_stat_t    q_stat;
  logic [3:0] mute_cfg_r, mute_cfg_nxt;
  logic       cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr[2] == 1'b0) ? {28'd0, mute_cfg_r} : 32'd0;

  always_comb begin
    mute_cfg_nxt = mute_cfg_r;
    if (cfg_wr && (cfg_paddr[2] == 1'b0)) begin
      mute_cfg_nxt = cfg_pwdata[3:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mute_cfg_r <= 4'd2;
    end else begin
      mute_cfg_r <= mute_cfg_nxt;
    end
  end

  dpd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .q_stat    (q_stat),
    .push      (push),
    .push_data (push_data)
  );

  dpd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .q_stat    (q_stat)
  );

  dpd_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .mute_confirm (mute_cfg_r),
    .head         (head),
    .q_stat       (q_stat),
    .pop          (pop),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .out_tuser    (out_tuser)
  );

  // queue never written when full
  assert property (@(posedge clk) disable iff (!rst_n) push |-> !q_stat.full)
    else $error("packet queue overflow");

  // queue never read when empty
  assert property (@(posedge clk) disable iff (!rst_n) pop |-> !q_stat.empty)
    else $error("packet queue underflow");

  // accepted flag agrees with packet kind
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser[0] == (out_tuser[3:1] != 3'd0)))
    else $error("accepted flag and kind disagree");

  // a recorded version always carries its known flag
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tdata[64:48] != 17'd0)) |-> out_tdata[33 + FlagVerKnown])
    else $error("version without known flag");

endmodule

`default_nettype wire
